[hw/rtl/stx_pkg.sv]
`default_nettype none

package stx_pkg;

   localparam int MAX_DEPTH_DEF = 64;
   localparam int DEPTH_W       = 7;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_AT        = 8'h40;
   localparam logic [7:0] CH_NEWLINE   = 8'h0a;
   localparam logic [7:0] CH_N         = 8'h6e;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_SEMI      = 8'h3b;
   localparam logic [7:0] CH_OPEN      = 8'h28;
   localparam logic [7:0] CH_CLOSE     = 8'h29;
   localparam logic [7:0] CH_SPACE     = 8'h20;

   typedef enum logic [2:0] {
      EV_CHAR       = 3'd0,
      EV_END        = 3'd1,
      EV_OPEN       = 3'd2,
      EV_CLOSE      = 3'd3,
      EV_UNMATCHED  = 3'd4,
      EV_UNBALANCED = 3'd5,
      EV_OVERFLOW   = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_MARK   = 2'd1,
      MODE_SKIP   = 2'd2
   } mode_type;

   typedef struct packed {
      event_type            ev;
      logic [7:0]           ch;
      logic [DEPTH_W-1:0]   dep;
      logic                 drp;
      logic                 last;
   } result_type;

   // up to two words per input byte, handed to the result queue together
   typedef struct packed {
      logic [1:0]  count;
      result_type  res0;
      result_type  res1;
   } push_type;

   function automatic logic is_atom_byte(input logic [7:0] b);
      logic r;
      r = ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a)) ||
          ((b >= 8'h30) && (b <= 8'h39)) ||
          (b == 8'h2e) || (b == 8'h2f) || (b == 8'h2d) || (b == 8'h5f) ||
          (b == 8'h21) || (b == 8'h3a) || (b == 8'h2a);
      return r;
   endfunction

   function automatic logic is_delim_byte(input logic [7:0] b);
      logic r;
      r = (b == CH_SPACE) || (b == CH_SEMI) || (b == CH_OPEN) || (b == CH_CLOSE) ||
          (b == CH_HASH) || (b == CH_QUOTE);
      return r;
   endfunction

   function automatic push_type push_event(input push_type p, input event_type ev,
                                           input logic [7:0] ch,
                                           input logic [DEPTH_W-1:0] dep,
                                           input logic drp);
      push_type   q;
      result_type r;
      q      = p;
      r.ev   = ev;
      r.ch   = ch;
      r.dep  = dep;
      r.drp  = drp;
      r.last = 1'b1;
      if (p.count == 2'd0) begin
         q.res0  = r;
         q.count = 2'd1;
      end else begin
         q.res0.last = 1'b0;
         q.res1      = r;
         q.count     = 2'd2;
      end
      return q;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/stx_core.sv]
`default_nettype none

module stx_core import stx_pkg::*; #(
   parameter int MaxDepth = MAX_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] byte_in,
   input  wire logic       end_of_input,
   output push_type        push
);

   localparam logic [DEPTH_W-1:0] MaxDepthW = DEPTH_W'(MaxDepth);

   mode_type           mode_ff, mode_in;
   logic               esc_ff, esc_in;
   logic               quote_ff, quote_in;
   logic               atom_ff, atom_in;
   logic               dnext_ff, dnext_in;
   logic               dact_ff, dact_in;
   logic [DEPTH_W-1:0] dlevel_ff, dlevel_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;

   always_comb begin
      push_type   p;
      logic [7:0] ch;
      logic       clear;
      p         = '0;
      ch        = byte_in;
      clear     = 1'b0;
      mode_in   = mode_ff;
      esc_in    = esc_ff;
      quote_in  = quote_ff;
      atom_in   = atom_ff;
      dnext_in  = dnext_ff;
      dact_in   = dact_ff;
      dlevel_in = dlevel_ff;
      depth_in  = depth_ff;

      if (end_of_input) begin
         if (depth_ff != '0) begin
            p = push_event(p, EV_UNBALANCED, 8'h00, depth_ff, 1'b0);
         end
         clear = 1'b1;
      end else begin
         case (mode_ff)
            MODE_MARK: begin
               if (byte_in == CH_AT) begin
                  dnext_in = 1'b1;
                  mode_in  = MODE_NORMAL;
               end else if (byte_in == CH_NEWLINE) begin
                  mode_in = MODE_NORMAL;
               end else begin
                  mode_in = MODE_SKIP;
               end
            end
            MODE_SKIP: begin
               if (byte_in == CH_NEWLINE) begin
                  mode_in = MODE_NORMAL;
               end
            end
            default: begin
               mode_in = MODE_NORMAL;
               if (esc_ff) begin
                  esc_in  = 1'b0;
                  atom_in = 1'b1;
                  if (byte_in == CH_N) begin
                     ch = CH_NEWLINE;
                  end
                  if (depth_ff != '0) begin
                     p = push_event(p, EV_CHAR, ch, depth_ff, dact_ff | dnext_ff);
                  end
               end else if (byte_in == CH_BACKSLASH) begin
                  esc_in = 1'b1;
               end else if (quote_ff) begin
                  if (byte_in == CH_QUOTE) begin
                     quote_in = 1'b0;
                     atom_in  = 1'b0;
                     if (depth_ff != '0) begin
                        p = push_event(p, EV_END, 8'h00, depth_ff, dact_ff | dnext_ff);
                        dnext_in = 1'b0;
                     end
                  end else begin
                     atom_in = 1'b1;
                     if (depth_ff != '0) begin
                        p = push_event(p, EV_CHAR, byte_in, depth_ff, dact_ff | dnext_ff);
                     end
                  end
               end else if (byte_in == CH_QUOTE) begin
                  quote_in = 1'b1;
               end else if (is_atom_byte(byte_in)) begin
                  atom_in = 1'b1;
                  if (depth_ff != '0) begin
                     p = push_event(p, EV_CHAR, byte_in, depth_ff, dact_ff | dnext_ff);
                  end
               end else begin
                  // a delimiter closes any atom in progress before acting
                  if (atom_ff && is_delim_byte(byte_in)) begin
                     atom_in = 1'b0;
                     if (depth_ff != '0) begin
                        p = push_event(p, EV_END, 8'h00, depth_ff, dact_ff | dnext_ff);
                        dnext_in = 1'b0;
                     end
                  end
                  if ((byte_in == CH_HASH) || (byte_in == CH_SEMI)) begin
                     mode_in = MODE_MARK;
                  end else if (byte_in == CH_OPEN) begin
                     if (depth_ff >= MaxDepthW) begin
                        p     = push_event(p, EV_OVERFLOW, 8'h00, depth_ff, 1'b0);
                        clear = 1'b1;
                     end else begin
                        p = push_event(p, EV_OPEN, 8'h00, depth_ff, dact_ff | dnext_in);
                        if (dnext_in && !dact_ff) begin
                           dact_in   = 1'b1;
                           dlevel_in = depth_ff;
                        end
                        dnext_in = 1'b0;
                        depth_in = depth_ff + DEPTH_W'(1);
                     end
                  end else if (byte_in == CH_CLOSE) begin
                     if (depth_ff == '0) begin
                        p     = push_event(p, EV_UNMATCHED, 8'h00, '0, 1'b0);
                        clear = 1'b1;
                     end else begin
                        depth_in = depth_ff - DEPTH_W'(1);
                        p = push_event(p, EV_CLOSE, 8'h00, depth_in, dact_ff);
                        if (dact_ff && (depth_in == dlevel_ff)) begin
                           dact_in = 1'b0;
                        end
                     end
                  end
               end
            end
         endcase
      end

      if (clear) begin
         mode_in   = MODE_NORMAL;
         esc_in    = 1'b0;
         quote_in  = 1'b0;
         atom_in   = 1'b0;
         dnext_in  = 1'b0;
         dact_in   = 1'b0;
         dlevel_in = '0;
         depth_in  = '0;
      end

      push = p;
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         esc_ff    <= 1'b0;
         quote_ff  <= 1'b0;
         atom_ff   <= 1'b0;
         dnext_ff  <= 1'b0;
         dact_ff   <= 1'b0;
         dlevel_ff <= '0;
         depth_ff  <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         esc_ff    <= esc_in;
         quote_ff  <= quote_in;
         atom_ff   <= atom_in;
         dnext_ff  <= dnext_in;
         dact_ff   <= dact_in;
         dlevel_ff <= dlevel_in;
         depth_ff  <= depth_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/stx_resq.sv]
`default_nettype none

module stx_resq import stx_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room,
   output logic          out_valid,
   input  wire logic     out_ready,
   output result_type    out_word
);

   result_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic                 pop;
   logic [QPTR_W-1:0]    wr_next;

   assign out_valid = (count_ff != '0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // keep space for a full pair of words from the next byte
   assign room      = (count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + QPTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + (QPTR_W + 1)'(push.count) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.res1;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/sexpr_tokenizer_unit.sv]
// channel   direction  handshake             words
// req_      in         req_valid/req_ready   one text byte or end marker
// rsp_      out        rsp_valid/rsp_ready   one event, last flags the final one
//
// a byte is taken in the cycle it arrives while req_ready is high; its one or
// two events go into a four-word result queue and leave one per cycle while
// rsp_ready is high. req_ready drops while fewer than two queue slots are
// free. synchronous reset empties the queue and clears all parse state.
`default_nettype none

module sexpr_tokenizer_unit import stx_pkg::*; #(
   parameter int MaxDepth = MAX_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_byte_in,
   input  wire logic               req_end_of_input,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_event_res,
   output logic [7:0]              rsp_char_out,
   output logic [DEPTH_W-1:0]      rsp_nest_depth,
   output logic                    rsp_dropped,
   output logic                    rsp_last
);

   push_type   push;
   result_type word;
   logic       room;
   logic       accept;

   assign req_ready = room;
   assign accept    = req_valid && room;

   stx_core #(
      .MaxDepth(MaxDepth)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_in      (req_byte_in),
      .end_of_input (req_end_of_input),
      .push         (push)
   );

   stx_resq u_resq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (word)
   );

   assign rsp_event_res  = word.ev;
   assign rsp_char_out   = word.ch;
   assign rsp_nest_depth = word.dep;
   assign rsp_dropped    = word.drp;
   assign rsp_last       = word.last;

endmodule

`default_nettype wire
